// File: rtl/core/pprl_pkg.sv
package pprl_pkg;

    // Register map, word index (byte address = 4 * index)
    localparam int unsigned CFG_AW = 5;
    localparam logic [2:0] REG_READ_INTERVAL = 3'd0;
    localparam logic [2:0] REG_SAMPLE_SPACING = 3'd1;
    localparam logic [2:0] REG_ON_FIRST = 3'd2;
    localparam logic [2:0] REG_ON_SECOND = 3'd3;
    localparam logic [2:0] REG_OFF_PULSE = 3'd4;
    localparam logic [2:0] REG_LOCKOUT = 3'd5;

    // Reset values of the registers
    localparam logic [15:0] RST_READ_INTERVAL = 16'd1000;
    localparam logic [7:0] RST_SAMPLE_SPACING = 8'd10;
    localparam logic [15:0] RST_ON_FIRST = 16'd500;
    localparam logic [15:0] RST_ON_SECOND = 16'd500;
    localparam logic [15:0] RST_OFF_PULSE = 16'd500;
    localparam logic [23:0] RST_LOCKOUT = 24'd180000;

    // Request codes on the op field
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ON = 2'd1;
    localparam logic [1:0] OP_OFF = 2'd2;

    typedef enum logic [1:0] {
        DRV_IDLE = 2'd0,
        DRV_ON = 2'd1,
        DRV_OFF = 2'd2
    } drive_phase_t;

    typedef enum logic [2:0] {
        RS_NONE = 3'd0,
        RS_STARTED = 3'd1,
        RS_LOCKED_OUT = 3'd2,
        RS_ALREADY_ON = 3'd3,
        RS_ALREADY_OFF = 3'd4
    } req_status_t;

    typedef struct packed {
        logic [15:0] read_interval;
        logic [7:0] sample_spacing;
        logic [15:0] on_first;
        logic [15:0] on_second;
        logic [15:0] off_pulse;
        logic [23:0] lockout;
    } pprl_cfg_t;

    // Debounce side state seen by the drive sequencer
    typedef struct packed {
        logic running;
        logic lockout_busy;
    } pprl_pump_t;

endpackage

// File: rtl/core/pprl_cfg.sv
module pprl_cfg (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [pprl_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output pprl_pkg::pprl_cfg_t cfg
);
    import pprl_pkg::*;

    pprl_cfg_t cfg_reg;
    pprl_cfg_t cfg_next;
    logic [2:0] idx;
    logic wr_en;

    assign idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_READ_INTERVAL:  cfg_next.read_interval = pwdata[15:0];
                REG_SAMPLE_SPACING: cfg_next.sample_spacing = pwdata[7:0];
                REG_ON_FIRST:       cfg_next.on_first = pwdata[15:0];
                REG_ON_SECOND:      cfg_next.on_second = pwdata[15:0];
                REG_OFF_PULSE:      cfg_next.off_pulse = pwdata[15:0];
                REG_LOCKOUT:        cfg_next.lockout = pwdata[23:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_READ_INTERVAL:  prdata = {16'd0, cfg_reg.read_interval};
            REG_SAMPLE_SPACING: prdata = {24'd0, cfg_reg.sample_spacing};
            REG_ON_FIRST:       prdata = {16'd0, cfg_reg.on_first};
            REG_ON_SECOND:      prdata = {16'd0, cfg_reg.on_second};
            REG_OFF_PULSE:      prdata = {16'd0, cfg_reg.off_pulse};
            REG_LOCKOUT:        prdata = {8'd0, cfg_reg.lockout};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_interval <= RST_READ_INTERVAL;
            cfg_reg.sample_spacing <= RST_SAMPLE_SPACING;
            cfg_reg.on_first <= RST_ON_FIRST;
            cfg_reg.on_second <= RST_ON_SECOND;
            cfg_reg.off_pulse <= RST_OFF_PULSE;
            cfg_reg.lockout <= RST_LOCKOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/pprl_drive.sv
module pprl_drive (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic [1:0] op,
    input  pprl_pkg::pprl_cfg_t cfg,
    input  pprl_pkg::pprl_pump_t pump,
    output pprl_pkg::drive_phase_t phase_next,
    output pprl_pkg::req_status_t status,
    output logic debounce_ok
);
    import pprl_pkg::*;

    drive_phase_t phase_reg;
    logic [16:0] wait_reg;
    logic [16:0] wait_next;
    logic pend_reg;
    logic pend_next;
    logic pend_on_reg;
    logic pend_on_next;
    logic [16:0] on_len;

    assign on_len = {1'b0, cfg.on_first} + {1'b0, cfg.on_second};

    always_comb
    begin
        phase_next = phase_reg;
        wait_next = wait_reg;
        pend_next = pend_reg;
        pend_on_next = pend_on_reg;
        status = RS_NONE;
        debounce_ok = 1'b1;

        // latest request wins over one still waiting
        if (op == OP_ON)
        begin
            pend_next = 1'b1;
            pend_on_next = 1'b1;
        end
        else if (op == OP_OFF)
        begin
            pend_next = 1'b1;
            pend_on_next = 1'b0;
        end

        if (phase_reg != DRV_IDLE)
        begin
            debounce_ok = 1'b0;
            if (wait_reg <= 17'd1)
            begin
                phase_next = DRV_IDLE;
                wait_next = 17'd0;
            end
            else
            begin
                wait_next = wait_reg - 17'd1;
            end
        end
        else if (pend_next)
        begin
            pend_next = 1'b0;
            if (pend_on_next)
            begin
                if (pump.lockout_busy)
                    status = RS_LOCKED_OUT;
                else if (pump.running)
                    status = RS_ALREADY_ON;
                else
                begin
                    status = RS_STARTED;
                    phase_next = DRV_ON;
                    wait_next = on_len;
                    debounce_ok = 1'b0;
                end
            end
            else
            begin
                if (!pump.running)
                    status = RS_ALREADY_OFF;
                else
                begin
                    status = RS_STARTED;
                    phase_next = DRV_OFF;
                    wait_next = {1'b0, cfg.off_pulse};
                    debounce_ok = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DRV_IDLE;
            wait_reg <= 17'd0;
            pend_reg <= 1'b0;
            pend_on_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            wait_reg <= wait_next;
            pend_reg <= pend_next;
            pend_on_reg <= pend_on_next;
        end
    end

endmodule

// File: rtl/core/pprl_debounce.sv
module pprl_debounce (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic contact,
    input  logic debounce_ok,
    input  pprl_pkg::pprl_cfg_t cfg,
    output pprl_pkg::pprl_pump_t pump,
    output logic running_next,
    output logic [23:0] lock_next
);
    import pprl_pkg::*;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [2:0] hs_reg;
    logic [2:0] hs_next;
    logic [2:0] hs_sum;
    logic [15:0] wait_reg;
    logic [15:0] wait_next;
    logic running_reg;
    logic [23:0] lock_reg;
    logic [23:0] lock_dec;

    // lockout counts down first, the drive side sees the decremented value
    assign lock_dec = (lock_reg != 24'd0) ? lock_reg - 24'd1 : lock_reg;
    assign pump.running = running_reg;
    assign pump.lockout_busy = (lock_dec != 24'd0);
    assign hs_sum = (phase_reg == 2'd0) ? {2'b00, contact} : hs_reg + {2'b00, contact};

    always_comb
    begin
        phase_next = phase_reg;
        hs_next = hs_reg;
        wait_next = wait_reg;
        running_next = running_reg;
        lock_next = lock_dec;
        if (debounce_ok)
        begin
            if (wait_reg != 16'd0)
                wait_next = wait_reg - 16'd1;
            else
            begin
                hs_next = hs_sum;
                if (phase_reg == 2'd3)
                begin
                    phase_next = 2'd0;
                    wait_next = cfg.read_interval;
                    if (hs_sum == 3'd4)
                        running_next = 1'b1;
                    else if (hs_sum == 3'd0)
                    begin
                        if (running_reg)
                            lock_next = cfg.lockout;
                        running_next = 1'b0;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                    wait_next = (cfg.sample_spacing == 8'd0) ? 16'd0
                              : {8'd0, cfg.sample_spacing - 8'd1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            hs_reg <= 3'd0;
            wait_reg <= 16'd0;
            running_reg <= 1'b0;
            lock_reg <= 24'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hs_reg <= hs_next;
            wait_reg <= wait_next;
            running_reg <= running_next;
            lock_reg <= lock_next;
        end
    end

endmodule

// File: rtl/core/pump_pulse_control_with_restart_lockout.sv
// Pump pulse controller with restart lockout. Every input word is one 1 ms
// tick carrying the pump contact level and an optional on/off request; every
// input word yields exactly one result word with the drive line levels, the
// debounced pump state, the lockout countdown and the status of a request
// served on that tick. One word is taken per clock cycle, sustained, while
// the result register is free or being emptied; a word goes through an input
// register and a result register, so its result word is valid on the master side
// once in the result register and can be taken at the next edge. All tick arithmetic
// (debounce counters, pulse timer, lockout countdown) sits between those two
// registers. Registers are written over the APB port at byte address 4*index
// and should only be changed while no word is in flight.
module pump_pulse_control_with_restart_lockout (
    input  logic clk,
    input  logic rst_n,
    // slave side
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [0] contact, [2:1] op
    // master side
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] on_drive, [1] off_drive, [2] pump_running,
                                        // [3] lockout_active, [27:4] lockout_left_ms,
                                        // [30:28] request_status
    // configuration
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [pprl_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import pprl_pkg::*;

    pprl_cfg_t cfg;
    pprl_pump_t pump;
    drive_phase_t phase_next;
    req_status_t status;
    logic debounce_ok;
    logic running_next;
    logic [23:0] lock_next;

    // input register
    logic in_valid_reg;
    logic contact_reg;
    logic [1:0] op_reg;

    // result register
    logic out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;

    logic advance;      // result register free or being emptied
    logic step;         // one tick is evaluated and retired this cycle

    assign advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step = in_valid_reg && advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    pprl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // drive sequencer runs first; it decides if debounce may run this tick
    pprl_drive u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .op          (op_reg),
        .cfg         (cfg),
        .pump        (pump),
        .phase_next  (phase_next),
        .status      (status),
        .debounce_ok (debounce_ok)
    );

    pprl_debounce u_debounce (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .contact      (contact_reg),
        .debounce_ok  (debounce_ok),
        .cfg          (cfg),
        .pump         (pump),
        .running_next (running_next),
        .lock_next    (lock_next)
    );

    // result reflects state after the tick
    assign out_data_next = {1'b0,
                            status,
                            lock_next,
                            (lock_next != 24'd0),
                            running_next,
                            (phase_next == DRV_OFF),
                            (phase_next == DRV_ON)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            contact_reg <= s_axis_tdata[0];
            op_reg <= s_axis_tdata[2:1];
        end
        if (step)
            out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/pprl_checker.sv
module pprl_checker (
    input logic clk,
    input logic rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import pprl_pkg::*;

    // the two drive lines are never raised together
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("on and off drive both high");

    // lockout flag agrees with the remaining count
    a_lock_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[27:4] != 24'd0)))
        else $error("lockout flag disagrees with count");

    // a started request raises one drive line in the same word
    a_started_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[30:28] == RS_STARTED))
        |-> (m_axis_tdata[0] || m_axis_tdata[1]))
        else $error("request started without drive");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

bind pump_pulse_control_with_restart_lockout pprl_checker u_pprl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
